// ----- hw/rtl/tcw_pkg.sv -----
// shared types, codes and defaults for the text console character writer
`default_nettype none

package tcw_pkg;

    // default geometry
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int AIN_W  = 11;
    localparam int LOC_W  = 11;
    localparam int VAL_W  = 16;
    localparam int ATTR_W = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // memory operation requested by the controller
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_PUT,
        MEM_READ,
        MEM_COPY,
        MEM_FLUSH,
        MEM_FILL
    } t_mem_op;

    typedef struct packed {
        logic    capture;   // take the input transaction payload
        logic    exec;      // apply the cursor update of the held item
        t_mem_op mem_op;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    fill_rst;  // blank with the reset attribute
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic is_read;
        logic need_scroll;
        logic cnt_copy_end;
        logic cnt_fill_end;
    } t_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/tcw_dpath.sv -----
// datapath: cursor, attribute, screen memory, sweep counter and result registers
`default_nettype none

module tcw_dpath #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    input  wire logic [tcw_pkg::ATTR_W-1:0] i_cfg_text_attribute,
    input  wire logic [tcw_pkg::OP_W-1:0]   i_op,
    input  wire logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic [tcw_pkg::AIN_W-1:0]  i_cell_address,
    input  tcw_pkg::t_cmd                   i_cmd,
    output tcw_pkg::t_sts                   o_sts,
    output logic [tcw_pkg::LOC_W-1:0]       o_cursor_location,
    output logic [tcw_pkg::VAL_W-1:0]       o_cell_value
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int COL_SUM_W  = $clog2(COLUMNS + TAB_STOP + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int PH_W       = $clog2(TAB_STOP);
    localparam int COPY_LAST  = (ROWS - 1) * COLUMNS - 1;

    logic [VAL_W-1:0] r_mem [CELL_COUNT];

    logic [ATTR_W-1:0] r_attr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PH_W-1:0]   r_tab_phase;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_wr_pend;
    logic [VAL_W-1:0]  r_rd_data;
    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_char;
    logic [AIN_W-1:0]  r_addr;

    logic [COL_SUM_W-1:0] n_col_sum;
    logic [PH_W-1:0]      n_tab_phase;
    logic [ROW_W-1:0]     n_row;
    logic                 row_adv;
    logic                 need_scroll;
    logic                 put_wr;
    logic                 addr_ok;
    logic [ADDR_W-1:0]    put_idx;
    logic [ADDR_W-1:0]    copy_src;
    logic [VAL_W-1:0]     blank;

    assign addr_ok  = (32'(r_addr) < 32'(CELL_COUNT));
    assign put_idx  = ADDR_W'(32'(r_row) * COLUMNS + 32'(r_col));
    assign copy_src = ADDR_W'(32'(r_cnt) + COLUMNS);
    assign blank    = i_cmd.fill_rst ? {ATTR_RESET, CH_SPACE} : {r_attr, CH_SPACE};

    // cursor movement for a put item; phase tracks column modulo tab stop
    always_comb begin
        n_col_sum   = COL_SUM_W'(r_col);
        n_tab_phase = r_tab_phase;
        row_adv     = 1'b0;
        put_wr      = 1'b0;
        if (r_op == OP_PUT) begin
            priority if (r_char == CH_BS) begin
                if (r_col != '0) begin
                    n_col_sum   = COL_SUM_W'(r_col) - 1'b1;
                    n_tab_phase = (r_tab_phase == '0) ? PH_W'(TAB_STOP - 1)
                                                      : r_tab_phase - 1'b1;
                end
            end else if (r_char == CH_TAB) begin
                n_col_sum   = COL_SUM_W'(r_col) + COL_SUM_W'(TAB_STOP)
                              - COL_SUM_W'(r_tab_phase);
                n_tab_phase = '0;
            end else if (r_char == CH_CR) begin
                n_col_sum   = '0;
                n_tab_phase = '0;
            end else if (r_char == CH_LF) begin
                n_col_sum   = '0;
                n_tab_phase = '0;
                row_adv     = 1'b1;
            end else if (r_char >= CH_SPACE && r_char <= CH_LAST) begin
                put_wr      = 1'b1;
                n_col_sum   = COL_SUM_W'(r_col) + 1'b1;
                n_tab_phase = (r_tab_phase == PH_W'(TAB_STOP - 1)) ? '0
                                                                   : r_tab_phase + 1'b1;
            end else begin
                n_col_sum   = COL_SUM_W'(r_col);
            end
            // column overflow wraps to the next row
            if (n_col_sum >= COL_SUM_W'(COLUMNS)) begin
                n_col_sum   = '0;
                n_tab_phase = '0;
                row_adv     = 1'b1;
            end
        end
        need_scroll = row_adv && (r_row == ROW_W'(ROWS - 1));
        n_row       = (row_adv && !need_scroll) ? r_row + 1'b1 : r_row;
    end

    assign o_sts.is_clear     = (r_op == OP_CLEAR);
    assign o_sts.is_read      = (r_op == OP_READ);
    assign o_sts.need_scroll  = need_scroll;
    assign o_sts.cnt_copy_end = (r_cnt == ADDR_W'(COPY_LAST));
    assign o_sts.cnt_fill_end = (r_cnt == ADDR_W'(CELL_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= ATTR_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_tab_phase <= '0;
            r_cnt       <= '0;
            r_wr_pend   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_text_attribute;
            end
            if (i_cmd.exec) begin
                if (r_op == OP_PUT) begin
                    r_col       <= COL_W'(n_col_sum);
                    r_row       <= n_row;
                    r_tab_phase <= n_tab_phase;
                end else if (r_op == OP_CLEAR) begin
                    r_col       <= '0;
                    r_row       <= '0;
                    r_tab_phase <= '0;
                end
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_wr_pend <= (i_cmd.mem_op == MEM_COPY);
        end
    end

    // payload and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_char <= i_char_code;
            r_addr <= i_cell_address;
        end
        if (i_cmd.mem_op == MEM_COPY) begin
            r_wr_addr <= r_cnt;
        end
        if (i_cmd.out_load) begin
            o_cursor_location <= LOC_W'(32'(r_row) * COLUMNS + 32'(r_col));
            o_cell_value      <= (o_sts.is_read && addr_ok) ? r_rd_data : '0;
        end
    end

    // screen memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.mem_op)
            MEM_PUT: begin
                if (put_wr) begin
                    r_mem[put_idx] <= {r_attr, r_char};
                end
            end
            MEM_READ: begin
                if (addr_ok) begin
                    r_rd_data <= r_mem[ADDR_W'(r_addr)];
                end
            end
            MEM_COPY: begin
                r_rd_data <= r_mem[copy_src];
                if (r_wr_pend) begin
                    r_mem[r_wr_addr] <= r_rd_data;
                end
            end
            MEM_FLUSH: begin
                r_mem[r_wr_addr] <= r_rd_data;
            end
            MEM_FILL: begin
                r_mem[r_cnt] <= blank;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_ctrl.sv -----
// controller: sequences item execution, screen sweeps and result handoff
`default_nettype none

module tcw_ctrl (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  tcw_pkg::t_sts i_sts,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_FLUSH,
        S_FILL,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   out_free;

    assign out_free   = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '{capture: 1'b0, exec: 1'b0, mem_op: MEM_NONE, cnt_clr: 1'b0,
                    cnt_inc: 1'b0, fill_rst: 1'b0, out_load: 1'b0};
        unique case (r_state)
            S_INIT: begin
                o_cmd.mem_op   = MEM_FILL;
                o_cmd.fill_rst = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_sts.cnt_fill_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec    = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                o_cmd.mem_op  = i_sts.is_read ? MEM_READ : MEM_PUT;
                if (i_sts.is_clear) begin
                    n_state = S_FILL;
                end else if (i_sts.need_scroll) begin
                    n_state = S_COPY;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_COPY: begin
                o_cmd.mem_op  = MEM_COPY;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_copy_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.mem_op = MEM_FLUSH;
                n_state      = S_FILL;
            end
            S_FILL: begin
                o_cmd.mem_op  = MEM_FILL;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_fill_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/text_console_char_writer_unit.sv -----
// top level of the text console character writer
// flow: an item is taken in idle, executed, then handed off once the result channel
//   is free; a clear adds a blank sweep of every cell, a scrolling put a copy sweep,
//   a flush step and a blank sweep of the last row, each sweep one cell a cycle
// throughput: no new item is taken until the last result is handed off
// reset: synchronous active low; a clearing pass then blanks every cell with
//   attribute 0x0F while input ready stays low
`default_nettype none

module text_console_char_writer_unit #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration write channel: text attribute
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [tcw_pkg::ATTR_W-1:0] i_cfg_text_attribute,
    // input item channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [tcw_pkg::OP_W-1:0]   i_op,
    input  wire logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic [tcw_pkg::AIN_W-1:0]  i_cell_address,
    // result channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [tcw_pkg::LOC_W-1:0]       o_cursor_location,
    output logic [tcw_pkg::VAL_W-1:0]       o_cell_value
);
    import tcw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // attribute register takes any write; user must write only while idle, unchecked
    assign o_cfg_ready = 1'b1;

    // controller: handshakes, execute step, scroll copy and blank sweeps
    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: cursor, screen memory and result registers
    tcw_dpath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_text_attribute (i_cfg_text_attribute),
        .i_op                 (i_op),
        .i_char_code          (i_char_code),
        .i_cell_address       (i_cell_address),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .o_cursor_location    (o_cursor_location),
        .o_cell_value         (o_cell_value)
    );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// self-checking testbench for the text console character writer
module tb;
    import tcw_pkg::*;

    // geometry of the instance under test, kept at the package defaults
    localparam int COLUMNS    = COLUMNS_DEF;
    localparam int ROWS       = ROWS_DEF;
    localparam int TAB_STOP   = TAB_STOP_DEF;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // the op code that the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // a scroll or a clear walks the whole screen, and so does the reset clearing pass;
    // these give the longest quiet stretch that the watchdog has to allow
    localparam int WATCHDOG_LIMIT = 10 * CELL_COUNT;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PRINT_LIMIT    = 100;
    localparam int PHASE_ITEMS    = 175;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] char_code;
        logic [AIN_W-1:0]  cell_address;
    } console_item_t;

    typedef struct packed {
        logic [LOC_W-1:0] cursor_location;
        logic [VAL_W-1:0] cell_value;
    } console_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // block inputs, all known from time zero
    logic              cfg_valid          = 1'b0;
    logic [ATTR_W-1:0] cfg_text_attribute = ATTR_RESET;
    logic              in_valid           = 1'b0;
    logic [OP_W-1:0]   in_op              = OP_PUT;
    logic [CHAR_W-1:0] in_char_code       = '0;
    logic [AIN_W-1:0]  in_cell_address    = '0;
    logic              out_ready          = 1'b0;

    // block outputs
    logic              o_cfg_ready;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [LOC_W-1:0]  o_cursor_location;
    logic [VAL_W-1:0]  o_cell_value;

    text_console_char_writer_unit u_top (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_text_attribute (cfg_text_attribute),
        .i_in_valid           (in_valid),
        .o_in_ready           (o_in_ready),
        .i_op                 (in_op),
        .i_char_code          (in_char_code),
        .i_cell_address       (in_cell_address),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (out_ready),
        .o_cursor_location    (o_cursor_location),
        .o_cell_value         (o_cell_value)
    );

    // items waiting to be driven and results waiting to come back
    console_item_t   pending_items[$];
    console_result_t expected_results[$];

    int   items_queued    = 0;  // every item queued, ignored ones included
    int   results_checked = 0;  // results matched against an expectation
    int   stim_count      = 0;  // items that do something
    int   mismatch_count  = 0;
    int   stall_cycles    = 0;
    int   in_gap          = 0;
    int   out_stall       = 0;
    logic in_fire         = 1'b0;  // input transaction at the last rising edge
    logic idling          = 1'b1;  // random gaps and stalls on both sides

    // shadow copy of the console: screen, cursor and attribute register
    logic [VAL_W-1:0]  shadow_screen [CELL_COUNT];
    int                shadow_col;
    int                shadow_row;
    logic [ATTR_W-1:0] shadow_attr;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("mismatch at %0t: %0s got %0h want %0h", $realtime, what, got, want);
        end
    endtask

    // blank cells carry the attribute in force at the moment of blanking
    function automatic void blank_cells(input int first, input int last);
        for (int i = first; i < last; i++) begin
            shadow_screen[i] = {shadow_attr, CH_SPACE};
        end
    endfunction

    function automatic void clear_screen();
        blank_cells(0, CELL_COUNT);
        shadow_col = 0;
        shadow_row = 0;
    endfunction

    // applies one item to the shadow console and returns the result it should give
    function automatic console_result_t apply_console_item(input console_item_t item);
        console_result_t res;
        res.cell_value = '0;
        case (item.op)
            OP_PUT: begin
                case (item.char_code)
                    CH_BS: begin
                        // backspace at column zero leaves the cursor alone
                        if (shadow_col != 0) shadow_col--;
                    end
                    CH_TAB: shadow_col = shadow_col + TAB_STOP - shadow_col % TAB_STOP;
                    CH_CR:  shadow_col = 0;
                    CH_LF: begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                    default: begin
                        // printable bytes are stored, everything else is dropped
                        if (item.char_code >= CH_SPACE && item.char_code <= CH_LAST) begin
                            shadow_screen[shadow_row * COLUMNS + shadow_col] =
                                {shadow_attr, item.char_code};
                            shadow_col++;
                        end
                    end
                endcase
                // column overflow, from a printable byte or a tab, wraps
                if (shadow_col >= COLUMNS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                // falling off the bottom scrolls one row and blanks the last one
                if (shadow_row >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                        shadow_screen[i] = shadow_screen[i + COLUMNS];
                    end
                    blank_cells((ROWS - 1) * COLUMNS, CELL_COUNT);
                    shadow_row = ROWS - 1;
                end
            end
            OP_CLEAR: clear_screen();
            OP_READ: begin
                if (item.cell_address < CELL_COUNT) begin
                    res.cell_value = shadow_screen[item.cell_address];
                end
            end
            default: ;
        endcase
        res.cursor_location = LOC_W'(shadow_row * COLUMNS + shadow_col);
        return res;
    endfunction

    // input driver: a new transaction is offered only once the previous one went through
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else if (!in_valid || in_fire) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                // gap burst of random length, this one included
                in_valid <= 1'b0;
                in_gap   <= $urandom_range(0, 6);
            end else if (pending_items.size() != 0) begin
                in_valid <= 1'b1;
                {in_op, in_char_code, in_cell_address} <= pending_items.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure in bursts of random length
    always @(negedge clk) begin
        if (out_stall > 0) begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            out_stall <= $urandom_range(0, 6);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: tracks configuration, predicts on each input transaction and checks
    // each result transaction against the oldest expectation
    always @(posedge clk) begin : monitor
        console_result_t want;
        in_fire <= in_valid && o_in_ready;
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready) shadow_attr = cfg_text_attribute;
            // check before predicting, so a result can never match an item taken
            // in the same cycle
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected, cursor_location",
                                    32'(o_cursor_location), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_cursor_location !== want.cursor_location) begin
                        report_mismatch("cursor_location", 32'(o_cursor_location),
                                        32'(want.cursor_location));
                    end
                    if (o_cell_value !== want.cell_value) begin
                        report_mismatch("cell_value", 32'(o_cell_value),
                                        32'(want.cell_value));
                    end
                    results_checked++;
                end
            end
            if (in_valid && o_in_ready) begin
                expected_results.push_back(
                    apply_console_item({in_op, in_char_code, in_cell_address}));
            end
        end
    end

    // watchdog on cycles in which no transaction of any kind happens
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [AIN_W-1:0] any_address();
        return AIN_W'($urandom);
    endfunction

    function automatic logic [CHAR_W-1:0] any_char();
        return CHAR_W'($urandom);
    endfunction

    task automatic push_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] code,
                             input logic [AIN_W-1:0] addr);
        logic dropped;
        // bytes that a put ignores and the unused op do not count as real work
        dropped = (op == OP_UNUSED) ||
                  (op == OP_PUT && (code > CH_LAST ||
                   (code < CH_SPACE && code != CH_BS && code != CH_TAB &&
                    code != CH_LF && code != CH_CR)));
        pending_items.push_back({op, code, addr});
        items_queued++;
        if (!dropped) stim_count++;
    endtask

    // waits until every queued item has returned its result
    task automatic wait_for_results();
        while (results_checked != items_queued) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one configuration transaction, issued only while the block is idle
    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(negedge clk);
        cfg_valid          <= 1'b1;
        cfg_text_attribute <= value;
        do @(posedge clk); while (!o_cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random console traffic: mostly text lines of random length with line ends,
    // so the cursor wraps, reaches the bottom and scrolls; reads, clears and
    // noise bytes and the unused op are mixed in
    task automatic random_phase(input int target);
        int                start;
        int                kind;
        int                len;
        int                pick;
        logic [CHAR_W-1:0] code;
        logic [AIN_W-1:0]  addr;
        start = stim_count;
        while (stim_count - start < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // text run; a few are long enough to wrap, tabs included
                len = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 100)
                                                  : $urandom_range(1, 15);
                repeat (len) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 86) begin
                        code = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
                        push_item(OP_PUT, code, any_address());
                    end else if (pick < 91) begin
                        push_item(OP_PUT, CH_TAB, any_address());
                    end else if (pick < 96) begin
                        push_item(OP_PUT, CH_BS, any_address());
                    end else begin
                        push_item(OP_PUT, CH_CR, any_address());
                    end
                end
            end else if (kind < 68) begin
                // line end, sometimes with blank lines after it
                if ($urandom_range(0, 1) == 1) push_item(OP_PUT, CH_CR, any_address());
                repeat ($urandom_range(1, 3)) push_item(OP_PUT, CH_LF, any_address());
            end else if (kind < 88) begin
                repeat ($urandom_range(1, 4)) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 17) addr = AIN_W'($urandom_range(0, CELL_COUNT - 1));
                    else if (pick == 17) addr = AIN_W'(CELL_COUNT - 1);
                    else addr = AIN_W'($urandom_range(CELL_COUNT, 2 ** AIN_W - 1));
                    push_item(OP_READ, any_char(), addr);
                end
            end else if (kind < 90) begin
                push_item(OP_CLEAR, any_char(), any_address());
            end else if (kind < 95) begin
                // control and high bytes; most are ignored
                if ($urandom_range(0, 1) == 1) code = CHAR_W'($urandom_range(8'h80, 8'hFF));
                else code = CHAR_W'($urandom_range(0, CH_SPACE - 1));
                push_item(OP_PUT, code, any_address());
            end else begin
                push_item(OP_UNUSED, any_char(), any_address());
            end
        end
    endtask

    initial begin
        shadow_attr = ATTR_RESET;
        clear_screen();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset attribute
        push_item(OP_READ, 8'h00, '0);                     // reset contents, first cell
        push_item(OP_READ, 8'hFF, AIN_W'(CELL_COUNT - 1)); // last cell
        push_item(OP_READ, 8'h00, AIN_W'(CELL_COUNT));     // just out of range
        push_item(OP_READ, 8'h00, '1);                     // top of the address field
        push_item(OP_PUT, CH_BS, '0);                      // backspace at column zero
        push_item(OP_PUT, CH_SPACE, '1);                   // lowest printable
        push_item(OP_PUT, CH_LAST, '0);                    // highest printable
        push_item(OP_PUT, CH_BS, '0);
        push_item(OP_PUT, 8'h41, '0);                      // overwrite after backspace
        push_item(OP_PUT, CH_TAB, '0);
        push_item(OP_PUT, CH_TAB, '0);                     // tab from a tab stop
        push_item(OP_PUT, CH_CR, '0);
        push_item(OP_PUT, CH_LF, '0);
        push_item(OP_PUT, 8'h00, '0);                      // ignored bytes
        push_item(OP_PUT, CHAR_W'(CH_SPACE - 1), '0);
        push_item(OP_PUT, CHAR_W'(CH_LAST + 1), '0);
        push_item(OP_PUT, 8'hFF, '0);
        push_item(OP_PUT, 8'h0B, '0);
        push_item(OP_UNUSED, '1, '1);                      // unused op
        push_item(OP_READ, 8'h00, AIN_W'(0));
        push_item(OP_READ, 8'h00, AIN_W'(1));
        push_item(OP_CLEAR, '1, '1);
        push_item(OP_READ, 8'h00, AIN_W'(1));              // blank again after clear
        wait_for_results();

        // random phases under different attributes, extremes first; stored cells
        // keep the attribute they were written with
        write_attribute(8'hFF);
        random_phase(PHASE_ITEMS);
        wait_for_results();
        write_attribute(8'h00);
        random_phase(PHASE_ITEMS);
        wait_for_results();
        write_attribute(ATTR_W'($urandom));
        random_phase(PHASE_ITEMS);
        wait_for_results();

        // last phase runs at full rate on both sides
        idling <= 1'b0;
        write_attribute(ATTR_W'($urandom));
        random_phase(PHASE_ITEMS);
        wait_for_results();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_results.size() != 0) begin
            report_mismatch("results never returned", 32'(expected_results.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
